@@ src/gapf_pkg.sv @@
// shared types, constants and functions of the grid A* path finder
package gapf_pkg;

    localparam int GRID_WIDTH  = 8;
    localparam int GRID_HEIGHT = 8;
    localparam int OPEN_DEPTH  = 256;
    localparam int OPEN_AW     = $clog2(OPEN_DEPTH);
    localparam int CNT_W       = OPEN_AW + 1;
    localparam int CELL_W      = 6;
    localparam int COST_W      = 7;
    localparam int DIM_W       = 4;
    localparam int CELLS       = 64;
    localparam int PATH_W      = 7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic       blocked;
        logic [2:0] start_x;
        logic [2:0] start_y;
        logic [2:0] goal_x;
        logic [2:0] goal_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0] step_x;
        logic [2:0] step_y;
        logic       found;
        logic       last_step;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic search;
        logic scan_clear;
        logic scan_run;
        logic pop;
        logic load_g;
        logic dir_issue;
        logic dir_update;
        logic walk_step;
        logic walk_load;
        logic walk_end;
        logic emit_rd;
        logic emit_wr;
        logic fail_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic rd_pending;
        logic best_ok;
        logic cur_is_goal;
        logic dir_ok;
        logic dir_last;
        logic push_overflow;
        logic walk_go;
        logic out_free;
        logic emit_last;
    } stat_t;

    function automatic logic [COST_W-1:0] est(input logic [CELL_W-1:0] a,
                                              input logic [CELL_W-1:0] b);
        logic [2:0] dx;
        logic [2:0] dy;
        dx = (a[2:0] > b[2:0]) ? (a[2:0] - b[2:0]) : (b[2:0] - a[2:0]);
        dy = (a[5:3] > b[5:3]) ? (a[5:3] - b[5:3]) : (b[5:3] - a[5:3]);
        return COST_W'(dx) + COST_W'(dy);
    endfunction

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ src/grid_astar_path_finder.sv @@
// top level of the grid A* path finder
//
//   channel   signals                               direction
//   request   req_valid, req_ready, req_data        in
//   result    rsp_valid, rsp_ready, rsp_data        out
//   config    psel, penable, pwrite, paddr, pwdata  in, prdata/pready out
//
// a load request writes one obstacle cell; a search, before each pop, scans the
// open list one entry per cycle for its lowest-cost entry, then checks the four
// neighbors, then walks the path back from the goal and emits one result per cell
// reset clears the obstacle map valid bits and returns to idle
// a stalled result holds the sequencer; requests are taken only when idle
module grid_astar_path_finder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  gapf_pkg::in_item_t   req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output gapf_pkg::out_item_t  rsp_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gapf_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_lim;
    logic [DIM_W-1:0] height_lim;
    cmd_t             cmd;
    stat_t            stat;

    assign pready     = 1'b1;
    assign width_lim  = limit_dim(width_reg, DIM_W'(GRID_WIDTH));
    assign height_lim = limit_dim(height_reg, DIM_W'(GRID_HEIGHT));
    assign prdata     = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(8);
            height_reg <= DIM_W'(8);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[DIM_W-1:0];
            else
                height_reg <= pwdata[DIM_W-1:0];
        end
    end

    gapf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req_data.operation),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gapf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_data   (req_data),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .rsp_data   (rsp_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready)
    );

endmodule

@@ src/gapf_ctrl.sv @@
// search sequencer state machine of the grid A* path finder
module gapf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_op,
    output logic           req_ready,
    input  gapf_pkg::stat_t stat,
    output gapf_pkg::cmd_t  cmd
);
    import gapf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_POP   = 4'd2;
    localparam logic [3:0] ST_GCUR  = 4'd3;
    localparam logic [3:0] ST_DIR   = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_WALK  = 4'd6;
    localparam logic [3:0] ST_WALKW = 4'd7;
    localparam logic [3:0] ST_EMITR = 4'd8;
    localparam logic [3:0] ST_EMITW = 4'd9;
    localparam logic [3:0] ST_FAIL  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_op == OP_SEARCH)
                    begin
                        cmd.search = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done && !stat.rd_pending)
                    state_next = stat.best_ok ? ST_POP : ST_FAIL;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = stat.cur_is_goal ? ST_WALK : ST_GCUR;
            end
            ST_GCUR:
            begin
                cmd.load_g = 1'b1;
                state_next = ST_DIR;
            end
            ST_DIR:
            begin
                cmd.dir_issue = 1'b1;
                if (stat.dir_ok)
                    state_next = ST_CHK;
                else if (stat.dir_last)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_CHK:
            begin
                cmd.dir_update = 1'b1;
                if (stat.push_overflow)
                    state_next = ST_FAIL;
                else if (stat.dir_last)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                    state_next = ST_DIR;
            end
            ST_WALK:
            begin
                if (stat.walk_go)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WALKW;
                end
                else
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = ST_EMITR;
                end
            end
            ST_WALKW:
            begin
                cmd.walk_load = 1'b1;
                state_next    = ST_WALK;
            end
            ST_EMITR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ST_EMITW;
                end
            end
            ST_EMITW:
            begin
                cmd.emit_wr = 1'b1;
                state_next  = stat.emit_last ? ST_IDLE : ST_EMITR;
            end
            ST_FAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.fail_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ src/gapf_dp.sv @@
// grid, cost, open list and path storage with the search datapath
module gapf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gapf_pkg::cmd_t        cmd,
    output gapf_pkg::stat_t       stat,
    input  gapf_pkg::in_item_t    req_data,
    input  logic [3:0]           width_lim,
    input  logic [3:0]           height_lim,
    output gapf_pkg::out_item_t   rsp_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready
);
    import gapf_pkg::*;

    logic                      obs_mem [CELLS];
    logic [COST_W-1:0]         cost_mem [CELLS];
    logic [CELL_W-1:0]         pred_mem [CELLS];
    logic [COST_W+CELL_W-1:0]  open_mem [OPEN_DEPTH];
    logic [CELL_W-1:0]         stack_mem [CELLS];

    logic [CELLS-1:0]          obs_ok_reg;
    logic [CELLS-1:0]          known_reg;
    logic [OPEN_DEPTH-1:0]     live_reg;

    logic                      obs_rd_reg;
    logic [COST_W-1:0]         cost_rd_reg;
    logic [CELL_W-1:0]         pred_rd_reg;
    logic [COST_W+CELL_W-1:0]  open_rd_reg;
    logic [CELL_W-1:0]         stack_rd_reg;

    logic [CELL_W-1:0]         start_reg;
    logic [CELL_W-1:0]         goal_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          scan_reg;
    logic                      rd_pend_reg;
    logic                      rd_live_reg;
    logic [OPEN_AW-1:0]        rd_idx_reg;
    logic                      best_ok_reg;
    logic [COST_W-1:0]         best_f_reg;
    logic [OPEN_AW-1:0]        best_idx_reg;
    logic [CELL_W-1:0]         best_cell_reg;
    logic [CELL_W-1:0]         cur_reg;
    logic [COST_W-1:0]         gcur_reg;
    logic [1:0]                dir_reg;
    logic [CELL_W-1:0]         nb_reg;
    logic [CELL_W-1:0]         p_reg;
    logic [PATH_W-1:0]         n_reg;
    logic [PATH_W-1:0]         k_reg;
    logic                      out_valid_reg;
    out_item_t                 out_reg;

    logic [CELL_W-1:0]         s_cell;
    logic [CELL_W-1:0]         g_cell;
    logic [CELL_W-1:0]         ld_cell;
    logic [3:0]                nx;
    logic [3:0]                ny;
    logic                      under;
    logic                      dir_ok;
    logic [CELL_W-1:0]         nb;
    logic [COST_W-1:0]         t_cost;
    logic                      need;
    logic                      room;
    logic                      push_ok;
    logic [OPEN_AW-1:0]        scan_idx;
    logic [OPEN_AW-1:0]        push_idx;
    logic [PATH_W-1:0]         emit_addr;
    logic                      better;

    assign s_cell   = {req_data.start_y, req_data.start_x};
    assign g_cell   = {req_data.goal_y, req_data.goal_x};
    assign ld_cell  = {req_data.cell_y, req_data.cell_x};
    assign scan_idx = scan_reg[OPEN_AW-1:0];
    assign push_idx = cnt_reg[OPEN_AW-1:0];

    always_comb
    begin
        nx    = {1'b0, cur_reg[2:0]};
        ny    = {1'b0, cur_reg[5:3]};
        under = 1'b0;
        case (dir_reg)
            DIR_UP:
            begin
                under = (cur_reg[5:3] == 3'd0);
                ny    = ny - 4'd1;
            end
            DIR_RIGHT: nx = nx + 4'd1;
            DIR_DOWN:  ny = ny + 4'd1;
            DIR_LEFT:
            begin
                under = (cur_reg[2:0] == 3'd0);
                nx    = nx - 4'd1;
            end
            default: under = 1'b1;
        endcase
    end

    assign dir_ok    = !under && (nx < width_lim) && (ny < height_lim);
    assign nb        = {ny[2:0], nx[2:0]};
    assign t_cost    = gcur_reg + COST_W'(1);
    assign need      = !(obs_ok_reg[nb_reg] && obs_rd_reg)
                       && (!known_reg[nb_reg] || (t_cost < cost_rd_reg));
    assign room      = (cnt_reg < CNT_W'(OPEN_DEPTH));
    assign push_ok   = need && room;
    assign emit_addr = n_reg - PATH_W'(1) - k_reg;
    assign better    = rd_pend_reg && rd_live_reg
                       && (!best_ok_reg || (open_rd_reg[COST_W+CELL_W-1:CELL_W] < best_f_reg));

    assign stat.scan_done     = (scan_reg == cnt_reg);
    assign stat.rd_pending    = rd_pend_reg;
    assign stat.best_ok       = best_ok_reg;
    assign stat.cur_is_goal   = (best_cell_reg == goal_reg);
    assign stat.dir_ok        = dir_ok;
    assign stat.dir_last      = (dir_reg == DIR_LEFT);
    assign stat.push_overflow = need && !room;
    assign stat.walk_go       = known_reg[p_reg] && (p_reg != start_reg)
                                && (n_reg < PATH_W'(CELLS));
    assign stat.out_free      = !out_valid_reg || rsp_ready;
    assign stat.emit_last     = ((k_reg + PATH_W'(1)) == n_reg);

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            obs_mem[ld_cell] <= req_data.blocked;
        if (cmd.dir_issue)
            obs_rd_reg <= obs_mem[nb];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
            cost_mem[s_cell] <= '0;
        else if (cmd.dir_update && push_ok)
            cost_mem[nb_reg] <= t_cost;
        if (cmd.pop)
            cost_rd_reg <= cost_mem[best_cell_reg];
        else if (cmd.dir_issue)
            cost_rd_reg <= cost_mem[nb];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dir_update && push_ok)
            pred_mem[nb_reg] <= cur_reg;
        if (cmd.walk_step)
            pred_rd_reg <= pred_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
            open_mem[0] <= {est(s_cell, g_cell), s_cell};
        else if (cmd.dir_update && push_ok)
            open_mem[push_idx] <= {t_cost + est(nb_reg, goal_reg), nb_reg};
        if (cmd.scan_run)
            open_rd_reg <= open_mem[scan_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_step)
            stack_mem[n_reg[CELL_W-1:0]] <= p_reg;
        else if (cmd.walk_end && (n_reg < PATH_W'(CELLS)))
            stack_mem[n_reg[CELL_W-1:0]] <= start_reg;
        if (cmd.emit_rd)
            stack_rd_reg <= stack_mem[emit_addr[CELL_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            start_reg <= s_cell;
            goal_reg  <= g_cell;
        end
        if (cmd.scan_run && !stat.scan_done)
        begin
            rd_live_reg <= live_reg[scan_idx];
            rd_idx_reg  <= scan_idx;
        end
        if (cmd.scan_run && better)
        begin
            best_f_reg    <= open_rd_reg[COST_W+CELL_W-1:CELL_W];
            best_idx_reg  <= rd_idx_reg;
            best_cell_reg <= open_rd_reg[CELL_W-1:0];
        end
        if (cmd.pop)
        begin
            cur_reg <= best_cell_reg;
            p_reg   <= goal_reg;
        end
        if (cmd.load_g)
            gcur_reg <= cost_rd_reg;
        if (cmd.dir_issue && dir_ok)
            nb_reg <= nb;
        if (cmd.walk_load)
            p_reg <= pred_rd_reg;
        if (cmd.emit_wr)
        begin
            out_reg.step_x    <= stack_rd_reg[2:0];
            out_reg.step_y    <= stack_rd_reg[5:3];
            out_reg.found     <= 1'b1;
            out_reg.last_step <= stat.emit_last;
        end
        else if (cmd.fail_out)
        begin
            out_reg.step_x    <= '0;
            out_reg.step_y    <= '0;
            out_reg.found     <= 1'b0;
            out_reg.last_step <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_ok_reg    <= '0;
            known_reg     <= '0;
            live_reg      <= '0;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            best_ok_reg   <= 1'b0;
            dir_reg       <= DIR_UP;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                obs_ok_reg[ld_cell] <= 1'b1;
            if (cmd.search)
            begin
                known_reg   <= CELLS'(1) << s_cell;
                live_reg    <= OPEN_DEPTH'(1);
                cnt_reg     <= CNT_W'(1);
                scan_reg    <= '0;
                rd_pend_reg <= 1'b0;
                best_ok_reg <= 1'b0;
            end
            if (cmd.scan_clear)
            begin
                scan_reg    <= '0;
                rd_pend_reg <= 1'b0;
                best_ok_reg <= 1'b0;
            end
            if (cmd.scan_run)
            begin
                rd_pend_reg <= !stat.scan_done;
                if (!stat.scan_done)
                    scan_reg <= scan_reg + CNT_W'(1);
                if (better)
                    best_ok_reg <= 1'b1;
            end
            if (cmd.pop)
            begin
                live_reg[best_idx_reg] <= 1'b0;
                dir_reg                <= DIR_UP;
                n_reg                  <= '0;
            end
            if (cmd.dir_issue && !dir_ok)
                dir_reg <= dir_reg + 2'd1;
            if (cmd.dir_update)
            begin
                dir_reg <= dir_reg + 2'd1;
                if (push_ok)
                begin
                    known_reg[nb_reg]  <= 1'b1;
                    live_reg[push_idx] <= 1'b1;
                    cnt_reg            <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.walk_step)
                n_reg <= n_reg + PATH_W'(1);
            if (cmd.walk_end)
            begin
                k_reg <= '0;
                if (n_reg < PATH_W'(CELLS))
                    n_reg <= n_reg + PATH_W'(1);
            end
            if (cmd.emit_wr)
                k_reg <= k_reg + PATH_W'(1);
            if (out_valid_reg && rsp_ready)
                out_valid_reg <= 1'b0;
            if (cmd.emit_wr || cmd.fail_out)
                out_valid_reg <= 1'b1;
        end
    end

    a_search_one_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search |=> (cnt_reg == CNT_W'(1)) && live_reg[0])
        else $error("open list not seeded with the start cell");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OPEN_DEPTH))
        else $error("open list count beyond depth");

    a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= PATH_W'(CELLS))
        else $error("path length beyond grid size");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_wr |-> !out_valid_reg)
        else $error("path cell overwrites a pending result");

endmodule

@@ dv/grid_astar_path_finder_tb.sv @@
// self-checking grid A* testbench: directed table, register settings, receiver hold, random load/search
module grid_astar_path_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gapf_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int HOLD_CYCLES = 3000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    in_item_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    out_item_t rsp_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    grid_astar_path_finder i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [3:0] cols_reg;
    logic [3:0] rows_reg;
    logic obstacle[CELLS];
    out_item_t path_q[$];
    out_item_t first_exp;

    int errors;
    int cycles;
    bit idle_on;
    bit hold_rsp;

    typedef struct {
        in_item_t req;
        bit has_exp;
        out_item_t exp_first;
    } row_t;

    row_t rows[32];
    int n_rows;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_item_t mk(logic [5:0] c, logic f, logic l);
        out_item_t r;
        r.step_x = c[2:0];
        r.step_y = c[5:3];
        r.found = f;
        r.last_step = l;
        return r;
    endfunction

    function automatic int clamp_dim(logic [3:0] v, int m);
        int r;
        r = (v == 0) ? 1 : ((v > m) ? m : int'(v));
        return r;
    endfunction

    function automatic int manhattan(int a, int b);
        int dx;
        int dy;
        dx = (a % 8) - (b % 8);
        dy = (a / 8) - (b / 8);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx + dy;
    endfunction

    task automatic expect_result(out_item_t it);
        path_q.insert(path_q.size(), it);
    endtask

    task automatic predict_path(int s, int g);
        int w;
        int h;
        int g_cost[CELLS];
        bit known[CELLS];
        int pred[CELLS];
        int ofs[OPEN_DEPTH];
        int ocell[OPEN_DEPTH];
        bit olive[OPEN_DEPTH];
        int cnt;
        int best;
        int bf;
        int cur;
        int nx;
        int ny;
        int nb;
        int t;
        int n;
        int p;
        int stk[CELLS];
        int dx[4];
        int dy[4];
        w = clamp_dim(cols_reg, GRID_WIDTH);
        h = clamp_dim(rows_reg, GRID_HEIGHT);
        dx = '{0, 1, 0, -1};
        dy = '{-1, 0, 1, 0};
        for (int i = 0; i < CELLS; i++)
        begin
            g_cost[i] = 0;
            known[i] = 0;
            pred[i] = 0;
        end
        for (int i = 0; i < OPEN_DEPTH; i++) olive[i] = 0;
        known[s] = 1;
        ofs[0] = manhattan(s, g) & 127;
        ocell[0] = s;
        olive[0] = 1;
        cnt = 1;
        forever
        begin
            best = -1;
            bf = 0;
            for (int i = 0; i < cnt; i++)
                if (olive[i] && (best < 0 || ofs[i] < bf))
                begin
                    best = i;
                    bf = ofs[i];
                end
            if (best < 0) break;
            olive[best] = 0;
            cur = ocell[best];
            if (cur == g)
            begin
                p = g;
                n = 0;
                while (n < 64 && known[p] && p != s)
                begin
                    stk[n] = p;
                    n++;
                    p = pred[p];
                end
                if (n < 64)
                begin
                    stk[n] = s;
                    n++;
                end
                for (int k = 0; k < n; k++)
                    expect_result(mk(6'(stk[n - 1 - k]), 1'b1, k + 1 == n));
                return;
            end
            for (int d = 0; d < 4; d++)
            begin
                nx = cur % 8 + dx[d];
                ny = cur / 8 + dy[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                nb = ny * 8 + nx;
                if (obstacle[nb]) continue;
                t = (g_cost[cur] + 1) & 127;
                if (!known[nb] || t < g_cost[nb])
                begin
                    pred[nb] = cur;
                    g_cost[nb] = t;
                    known[nb] = 1;
                    if (cnt >= OPEN_DEPTH)
                    begin
                        expect_result(mk(6'd0, 1'b0, 1'b1));
                        return;
                    end
                    ofs[cnt] = (t + manhattan(nb, g)) & 127;
                    ocell[cnt] = nb;
                    olive[cnt] = 1;
                    cnt++;
                end
            end
        end
        expect_result(mk(6'd0, 1'b0, 1'b1));
    endtask

    task automatic predict(in_item_t r);
        int qn;
        qn = path_q.size();
        if (r.operation == OP_LOAD)
            obstacle[{r.cell_y, r.cell_x}] = r.blocked;
        else
        begin
            predict_path(int'({r.start_y, r.start_x}), int'({r.goal_y, r.goal_x}));
            first_exp = path_q[qn];
        end
    endtask

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send(in_item_t r);
        idle_gap();
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predict(r);
    endtask

    task automatic apb_write(logic idx, logic [3:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_WIDTH) cols_reg = v;
        else rows_reg = v;
        @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (path_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_row(in_item_t q, bit h, out_item_t e);
        rows[n_rows].req = q;
        rows[n_rows].has_exp = h;
        rows[n_rows].exp_first = e;
        n_rows++;
    endtask

    function automatic in_item_t load_req(int x, int y, logic b);
        in_item_t r;
        r = '0;
        r.operation = OP_LOAD;
        r.cell_x = 3'(x);
        r.cell_y = 3'(y);
        r.blocked = b;
        return r;
    endfunction

    function automatic in_item_t search_req(int sx, int sy, int gx, int gy);
        in_item_t r;
        r = '0;
        r.operation = OP_SEARCH;
        r.start_x = 3'(sx);
        r.start_y = 3'(sy);
        r.goal_x = 3'(gx);
        r.goal_y = 3'(gy);
        return r;
    endfunction

    function automatic in_item_t rand_req(bit noise);
        in_item_t r;
        r = in_item_t'($bits(in_item_t)'($urandom));
        if (!noise)
        begin
            r.operation = ($urandom_range(0, 2) == 0) ? OP_LOAD : OP_SEARCH;
            if (r.operation == OP_LOAD) r.blocked = ($urandom_range(0, 3) == 0);
        end
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (path_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", rsp_data);
            end
            else
            begin
                want = path_q.pop_front();
                if (rsp_data !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, rsp_data);
                end
            end
        end
    end

    // receiver stalls
    initial begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
                rsp_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        row_t rw;
        in_item_t r;
        errors = 0;
        n_rows = 0;
        idle_on = 1'b1;
        hold_rsp = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cols_reg = 4'd8;
        rows_reg = 4'd8;
        first_exp = '0;
        foreach (obstacle[i]) obstacle[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: first expected result typed where obvious
        add_row(search_req(0, 0, 0, 0), 1'b1, mk(6'd0, 1'b1, 1'b1));
        add_row(search_req(7, 7, 7, 7), 1'b1, mk(6'd63, 1'b1, 1'b1));
        add_row(search_req(0, 0, 7, 7), 1'b1, mk(6'd0, 1'b1, 1'b0));
        add_row(search_req(7, 7, 0, 0), 1'b1, mk(6'd63, 1'b1, 1'b0));
        add_row(load_req(7, 7, 1'b1), 1'b0, '0);
        add_row(search_req(0, 0, 7, 7), 1'b1, mk(6'd0, 1'b0, 1'b1));
        add_row(search_req(7, 7, 0, 0), 1'b0, '0);
        add_row(load_req(7, 7, 1'b0), 1'b0, '0);
        add_row(load_req(1, 0, 1'b1), 1'b0, '0);
        add_row(load_req(0, 1, 1'b1), 1'b0, '0);
        add_row(search_req(0, 0, 3, 3), 1'b1, mk(6'd0, 1'b0, 1'b1));
        add_row(search_req(3, 3, 0, 0), 1'b1, mk(6'd0, 1'b0, 1'b1));
        add_row(load_req(1, 0, 1'b0), 1'b0, '0);
        add_row(search_req(0, 0, 3, 3), 1'b0, '0);
        add_row(load_req(0, 1, 1'b0), 1'b0, '0);
        for (int i = 1; i < 7; i++) add_row(load_req(4, i, 1'b1), 1'b0, '0);
        add_row(search_req(2, 3, 6, 3), 1'b0, '0);
        add_row(search_req(5, 5, 2, 2), 1'b0, '0);
        for (int i = 0; i < n_rows; i++)
        begin
            rw = rows[i];
            send(rw.req);
            if (rw.has_exp && (first_exp !== rw.exp_first))
            begin
                errors++;
                if (errors <= 10)
                    $display("table mismatch: expected %p got %p", rw.exp_first, first_exp);
            end
        end
        for (int i = 1; i < 7; i++) send(load_req(4, i, 1'b0));
        drain();

        // register settings, extremes included; outside-grid goal fails
        apb_write(REG_WIDTH, 4'd1);
        apb_write(REG_HEIGHT, 4'd1);
        send(search_req(0, 0, 0, 0));
        send(search_req(0, 0, 1, 0));
        drain();
        apb_write(REG_WIDTH, 4'd0);
        apb_write(REG_HEIGHT, 4'd15);
        send(search_req(0, 0, 0, 7));
        send(search_req(5, 2, 0, 6));
        drain();
        apb_write(REG_WIDTH, 4'd3);
        apb_write(REG_HEIGHT, 4'd2);
        send(search_req(0, 0, 2, 1));
        send(search_req(0, 0, 5, 5));
        send(load_req(6, 6, 1'b1));
        drain();

        // long receiver hold while requests keep coming
        hold_rsp = 1'b1;
        for (int i = 0; i < 4; i++) send(search_req(0, 0, 2, 1));
        while (hold_rsp) @(posedge clk);
        drain();

        // random phases over several grid sizes
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin apb_write(REG_WIDTH, 4'd8); apb_write(REG_HEIGHT, 4'd8); end
                1: begin apb_write(REG_WIDTH, 4'd4); apb_write(REG_HEIGHT, 4'd6); end
                2: begin apb_write(REG_WIDTH, 4'd9); apb_write(REG_HEIGHT, 4'd3); end
                3: begin apb_write(REG_WIDTH, 4'd8); apb_write(REG_HEIGHT, 4'd8); end
                default: idle_on = 1'b0;
            endcase
            for (int i = 0; i < 20; i++)
            begin
                r = rand_req($urandom_range(0, 9) == 0);
                send(r);
            end
            drain();
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
src/gapf_pkg.sv
src/gapf_ctrl.sv
src/gapf_dp.sv
src/grid_astar_path_finder.sv
dv/grid_astar_path_finder_tb.sv
